FILE: rtl/core/tvpc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the timed valve position controller
// no dependencies

package tvpc_pkg;

  localparam int ANGLE_W       = 9;
  localparam int SEC_W         = 10;
  localparam int CMD_W         = 3;
  localparam int TGT_W         = 11;
  localparam int STATUS_W      = 3;
  localparam int MS_COUNT_BITS = 20;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  // |angle diff| * seconds * 1000 fits in 29 bits
  localparam int MULA_W        = ANGLE_W + SEC_W;
  localparam int PROD_W        = MULA_W + SEC_W;
  localparam int DIV_CNT_W     = $clog2(PROD_W);
  localparam int SAT_W         = 33;

  localparam logic [SEC_W-1:0] MS_PER_SECOND       = SEC_W'(1000);
  localparam logic [SEC_W-1:0] CALIB_EXTRA_SECONDS = SEC_W'(2);

  localparam logic [ANGLE_W-1:0] START_RESET = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] MAX_RESET   = ANGLE_W'(90);
  localparam logic [SEC_W-1:0]   SEC_RESET   = SEC_W'(90);

  typedef logic [MS_COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = {MS_COUNT_BITS{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_OPEN   = 3'd1,
    CMD_CLOSE  = 3'd2,
    CMD_HALF   = 3'd3,
    CMD_TARGET = 3'd4,
    CMD_CALIB  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_CALIBRATING = 3'd0,
    STS_OPENING     = 3'd1,
    STS_CLOSING     = 3'd2,
    STS_OPEN        = 3'd3,
    STS_HALF        = 3'd4,
    STS_CLOSED      = 3'd5,
    STS_OTHER       = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_START_ANGLE = 2'd0,
    REG_MAX_ANGLE   = 2'd1,
    REG_TRAVEL_SEC  = 2'd2,
    REG_CALIB_DIR   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_MUL1,
    DP_MUL2,
    DP_DIV,
    DP_DONE
  } dur_phase_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] max_angle;
    logic [SEC_W-1:0]   travel_seconds;
    logic               calib_direction;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] diff;
    logic [ANGLE_W-1:0] span;
    logic [SEC_W-1:0]   secs;
  } dur_req_t;

  typedef struct packed {
    logic   done;
    count_t dur;
  } dur_rsp_t;

  function automatic count_t sat_count(input logic [SAT_W-1:0] v);
    count_t r;
    if (v > SAT_W'(COUNT_MAX)) r = COUNT_MAX;
    else r = v[MS_COUNT_BITS-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/tvpc_stream_if.sv
`timescale 1ns / 1ps
// valid/ready channels for command items and status items
// depends on tvpc_pkg

interface tvpc_in_if import tvpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [TGT_W-1:0] target_angle;

  modport source (output valid, output cmd, output target_angle, input ready);
  modport sink (input valid, input cmd, input target_angle, output ready);
endinterface

interface tvpc_out_if import tvpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                open_relay;
  logic                close_relay;
  logic [ANGLE_W-1:0]  current_angle;
  logic [ANGLE_W-1:0]  goal_angle;
  logic                is_opening;
  logic                is_closing;
  logic                is_operating;
  logic                is_calibrating;
  logic [STATUS_W-1:0] status_code;

  modport source (output valid, output open_relay, output close_relay,
                  output current_angle, output goal_angle, output is_opening,
                  output is_closing, output is_operating, output is_calibrating,
                  output status_code, input ready);
  modport sink (input valid, input open_relay, input close_relay,
                input current_angle, input goal_angle, input is_opening,
                input is_closing, input is_operating, input is_calibrating,
                input status_code, output ready);
endinterface

FILE: rtl/core/tvpc_regs.sv
`timescale 1ns / 1ps
// apb configuration registers: angles, travel time, calibration relay
// depends on tvpc_pkg

module tvpc_regs import tvpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_angle     <= START_RESET;
      cfg.max_angle       <= MAX_RESET;
      cfg.travel_seconds  <= SEC_RESET;
      cfg.calib_direction <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_START_ANGLE: cfg.start_angle     <= pwdata[ANGLE_W-1:0];
        REG_MAX_ANGLE:   cfg.max_angle       <= pwdata[ANGLE_W-1:0];
        REG_TRAVEL_SEC:  cfg.travel_seconds  <= pwdata[SEC_W-1:0];
        REG_CALIB_DIR:   cfg.calib_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_ANGLE: prdata = DATA_W'(cfg.start_angle);
      REG_MAX_ANGLE:   prdata = DATA_W'(cfg.max_angle);
      REG_TRAVEL_SEC:  prdata = DATA_W'(cfg.travel_seconds);
      REG_CALIB_DIR:   prdata = DATA_W'(cfg.calib_direction);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/tvpc_dur_unit.sv
`timescale 1ns / 1ps
// move duration unit: one shared multiplier used twice, then a restoring
// divider retiring one quotient bit a cycle; depends on tvpc_pkg

module tvpc_dur_unit import tvpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dur_req_t req,
  output dur_rsp_t rsp
);

  dur_phase_t             phase, phase_next;
  logic [ANGLE_W-1:0]     diff_r;
  logic [ANGLE_W-1:0]     span_r;
  logic [SEC_W-1:0]       secs_r;
  logic [PROD_W-1:0]      dq;
  logic [ANGLE_W:0]       rem;
  logic [DIV_CNT_W-1:0]   cnt;

  logic [MULA_W-1:0]      mul_a;
  logic [SEC_W-1:0]       mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [ANGLE_W:0]       shifted;
  logic                   fits;

  // shared multiplier: diff*secs, then that product *1000
  assign mul_a   = (phase == DP_MUL1) ? MULA_W'(diff_r) : dq[MULA_W-1:0];
  assign mul_b   = (phase == DP_MUL1) ? secs_r : MS_PER_SECOND;
  assign mul_p   = {{SEC_W{1'b0}}, mul_a} * {{MULA_W{1'b0}}, mul_b};

  assign shifted = {rem[ANGLE_W-1:0], dq[PROD_W-1]};
  assign fits    = shifted >= {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (rst) phase <= DP_IDLE;
    else phase <= phase_next;
  end

  always_comb begin
    phase_next = phase;
    rsp.done   = 1'b0;
    rsp.dur    = '0;
    case (phase)
      DP_IDLE: if (req.start) phase_next = DP_MUL1;
      DP_MUL1: phase_next = DP_MUL2;
      DP_MUL2: phase_next = DP_DIV;
      DP_DIV:  if (cnt == DIV_CNT_W'(PROD_W - 1)) phase_next = DP_DONE;
      DP_DONE: begin
        rsp.done   = 1'b1;
        // zero span means no travel time
        rsp.dur    = (span_r == '0) ? '0 : sat_count(SAT_W'(dq));
        phase_next = DP_IDLE;
      end
      default: phase_next = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (phase)
      DP_IDLE: begin
        diff_r <= req.diff;
        span_r <= req.span;
        secs_r <= req.secs;
      end
      DP_MUL1: dq <= mul_p;
      DP_MUL2: begin
        dq  <= mul_p;
        rem <= '0;
        cnt <= '0;
      end
      DP_DIV: begin
        rem <= fits ? (shifted - {1'b0, span_r}) : shifted;
        dq  <= {dq[PROD_W-2:0], fits};
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/timed_valve_position_controller.sv
`timescale 1ns / 1ps
// command items: accept moves the sequencer to its EMIT state, which loads the output register; tick
//   items pass through the CALC state while the duration unit runs its 29-step restoring divider
// throughput: one item at a time; a new item is accepted only once its status item is emitted;
//   one waiting status item does not hold up the next accept
// reset: synchronous, active high; angles 0, relays off, no move or calibration,
//   registers to open 0, closed 90, travel 90 s, calibrate on open relay
// depends on tvpc_pkg, tvpc_stream_if, tvpc_regs, tvpc_dur_unit

module timed_valve_position_controller import tvpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  tvpc_in_if.sink           in_ch,
  tvpc_out_if.source        out_ch
);

  cfg_t     cfg;
  dur_req_t dreq;
  dur_rsp_t drsp;

  // sequencer and valve state
  state_t             state, state_next;
  logic [ANGLE_W-1:0] angle_now, angle_now_next;
  logic [ANGLE_W-1:0] angle_goal, angle_goal_next;
  logic               relay_open_on, relay_open_on_next;
  logic               relay_close_on, relay_close_on_next;
  logic               moving_open, moving_open_next;
  logic               moving_close, moving_close_next;
  logic               move_active, move_active_next;
  logic               calib_active, calib_active_next;
  count_t             move_elapsed, move_elapsed_next;
  count_t             calib_elapsed, calib_elapsed_next;

  logic               accept;
  logic               slot_free;
  logic signed [ANGLE_W:0] span_s;
  logic signed [ANGLE_W:0] half_off;
  logic [ANGLE_W-1:0] half_angle;
  logic signed [TGT_W-1:0] tgt;
  count_t             calib_limit;
  count_t             me_inc;
  count_t             ce_inc;
  status_t            status;

  tvpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tvpc_dur_unit u_dur (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_ch.valid || out_ch.ready;
  assign tgt         = in_ch.target_angle;

  // half angle: start + (max - start)/2, the halving truncating toward zero
  assign span_s     = $signed({1'b0, cfg.max_angle}) - $signed({1'b0, cfg.start_angle});
  assign half_off   = (span_s + $signed({{ANGLE_W{1'b0}}, span_s[ANGLE_W]})) >>> 1;
  assign half_angle = ANGLE_W'($signed({1'b0, cfg.start_angle}) + half_off);

  // duration operands are taken on the tick's accept, before any state change
  always_comb begin
    dreq.start = accept && (in_ch.cmd == CMD_TICK);
    dreq.diff  = (angle_now > angle_goal) ? (angle_now - angle_goal)
                                          : (angle_goal - angle_now);
    dreq.span  = (cfg.max_angle >= cfg.start_angle) ? (cfg.max_angle - cfg.start_angle)
                                                    : (cfg.start_angle - cfg.max_angle);
    dreq.secs  = cfg.travel_seconds;
  end

  // calibration runs for travel time plus two seconds
  assign calib_limit = sat_count((SAT_W'(cfg.travel_seconds) + SAT_W'(CALIB_EXTRA_SECONDS))
                                 * SAT_W'(MS_PER_SECOND));

  // elapsed counters advance first on a tick and stick at full scale
  assign me_inc = (move_active && move_elapsed < COUNT_MAX) ? move_elapsed + 1'b1
                                                             : move_elapsed;
  assign ce_inc = (calib_active && calib_elapsed < COUNT_MAX) ? calib_elapsed + 1'b1
                                                               : calib_elapsed;

  always_comb begin
    state_next          = state;
    angle_now_next      = angle_now;
    angle_goal_next     = angle_goal;
    relay_open_on_next  = relay_open_on;
    relay_close_on_next = relay_close_on;
    moving_open_next    = moving_open;
    moving_close_next   = moving_close;
    move_active_next    = move_active;
    calib_active_next   = calib_active;
    move_elapsed_next   = move_elapsed;
    calib_elapsed_next  = calib_elapsed;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EMIT;
          case (cmd_t'(in_ch.cmd))
            CMD_TICK: state_next = ST_CALC;
            CMD_OPEN: if (angle_now != cfg.start_angle) angle_goal_next = cfg.start_angle;
            CMD_CLOSE: if (angle_now != cfg.max_angle) angle_goal_next = cfg.max_angle;
            CMD_HALF: if (angle_now != half_angle) angle_goal_next = half_angle;
            CMD_TARGET: begin
              // clamp into start..max, low bound checked first
              if (tgt != $signed({2'b00, angle_goal})) begin
                if (tgt < $signed({2'b00, cfg.start_angle})) begin
                  angle_goal_next = cfg.start_angle;
                end else if (tgt > $signed({2'b00, cfg.max_angle})) begin
                  angle_goal_next = cfg.max_angle;
                end else begin
                  angle_goal_next = tgt[ANGLE_W-1:0];
                end
              end
            end
            CMD_CALIB: begin
              // a running move carries on; the calibration count restarts
              if (cfg.calib_direction) relay_close_on_next = 1'b1;
              else relay_open_on_next = 1'b1;
              calib_active_next  = 1'b1;
              calib_elapsed_next = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        if (drsp.done) begin
          state_next         = ST_EMIT;
          move_elapsed_next  = me_inc;
          calib_elapsed_next = ce_inc;
          // idle and off target: energise the relay toward the goal
          if (!move_active && !calib_active && angle_now != angle_goal) begin
            if (angle_now > angle_goal) begin
              relay_open_on_next = 1'b1;
              moving_open_next   = 1'b1;
            end else begin
              relay_close_on_next = 1'b1;
              moving_close_next   = 1'b1;
            end
            move_active_next  = 1'b1;
            move_elapsed_next = '0;
          end
          if (calib_active && ce_inc >= calib_limit) begin
            relay_open_on_next  = 1'b0;
            relay_close_on_next = 1'b0;
            calib_active_next   = 1'b0;
          end
          // move finished: relays off, angle taken as reached
          if (move_active_next && move_elapsed_next >= drsp.dur) begin
            relay_open_on_next  = 1'b0;
            relay_close_on_next = 1'b0;
            moving_open_next    = 1'b0;
            moving_close_next   = 1'b0;
            move_active_next    = 1'b0;
            angle_now_next      = angle_goal;
          end
        end
      end
      ST_EMIT: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      angle_now      <= '0;
      angle_goal     <= '0;
      relay_open_on  <= 1'b0;
      relay_close_on <= 1'b0;
      moving_open    <= 1'b0;
      moving_close   <= 1'b0;
      move_active    <= 1'b0;
      calib_active   <= 1'b0;
      move_elapsed   <= '0;
      calib_elapsed  <= '0;
    end else begin
      state          <= state_next;
      angle_now      <= angle_now_next;
      angle_goal     <= angle_goal_next;
      relay_open_on  <= relay_open_on_next;
      relay_close_on <= relay_close_on_next;
      moving_open    <= moving_open_next;
      moving_close   <= moving_close_next;
      move_active    <= move_active_next;
      calib_active   <= calib_active_next;
      move_elapsed   <= move_elapsed_next;
      calib_elapsed  <= calib_elapsed_next;
    end
  end

  // status in priority order from the settled state
  always_comb begin
    if (calib_active) status = STS_CALIBRATING;
    else if (moving_open) status = STS_OPENING;
    else if (moving_close) status = STS_CLOSING;
    else if (angle_now == cfg.start_angle) status = STS_OPEN;
    else if (angle_now == half_angle) status = STS_HALF;
    else if (angle_now == cfg.max_angle) status = STS_CLOSED;
    else status = STS_OTHER;
  end

  // output register: holds the status item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      out_ch.open_relay     <= relay_open_on;
      out_ch.close_relay    <= relay_close_on;
      out_ch.current_angle  <= angle_now;
      out_ch.goal_angle     <= angle_goal;
      out_ch.is_opening     <= moving_open;
      out_ch.is_closing     <= moving_close;
      out_ch.is_operating   <= move_active;
      out_ch.is_calibrating <= calib_active;
      out_ch.status_code    <= status;
    end
  end

endmodule
